### rtl/core/vfg_pkg.sv
// Shared constants for the visual fix gate and loss tracker.
// Holds register indexes, item mode codes, loss codes and fixed widths; no dependencies.
`default_nettype none

package vfg_pkg;

  // Fixed register widths
  localparam int JUMP_W     = 23;
  localparam int TIMEOUT_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int SQ_W       = 2 * JUMP_W;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_JUMP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TMO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TMO  = 2'd2;

  // Register reset values
  localparam logic [JUMP_W-1:0]    MAX_JUMP_RST  = 23'd1000;
  localparam logic [SQ_W-1:0]      MAX_SQ_RST    = 46'd1000000;
  localparam logic [TIMEOUT_W-1:0] SHORT_TMO_RST = 32'd500;
  localparam logic [TIMEOUT_W-1:0] LONG_TMO_RST  = 32'd2000;

  // Request modes; the unused code behaves as a tick
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_FIX   = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Loss levels
  localparam logic [1:0] LOSS_FRESH = 2'd0;
  localparam logic [1:0] LOSS_SHORT = 2'd1;
  localparam logic [1:0] LOSS_LONG  = 2'd2;

endpackage

`default_nettype wire

### rtl/core/vfg_if.sv
// Valid/ready channel interfaces for the visual fix gate and loss tracker.
// Depends on vfg_pkg for the configuration channel widths.
`default_nettype none

interface vfg_in_if #(
  parameter int POS_BITS  = 24,
  parameter int TIME_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  mode;
  logic [TIME_BITS-1:0]        stamp_ms;
  logic signed [POS_BITS-1:0]  north_mm;
  logic signed [POS_BITS-1:0]  east_mm;
  logic signed [POS_BITS-1:0]  down_mm;
  logic                        currently_seen;

  modport source (output valid, mode, stamp_ms, north_mm, east_mm, down_mm,
                  currently_seen, input ready);
  modport sink   (input valid, mode, stamp_ms, north_mm, east_mm, down_mm,
                  currently_seen, output ready);
endinterface

interface vfg_out_if #(
  parameter int POS_BITS = 24
);
  logic                        valid;
  logic                        ready;
  logic                        fix_accepted;
  logic                        fix_fresh;
  logic signed [POS_BITS-1:0]  held_north_mm;
  logic signed [POS_BITS-1:0]  held_east_mm;
  logic signed [POS_BITS-1:0]  held_down_mm;
  logic [1:0]                  loss_level;

  modport source (output valid, fix_accepted, fix_fresh, held_north_mm, held_east_mm,
                  held_down_mm, loss_level, input ready);
  modport sink   (input valid, fix_accepted, fix_fresh, held_north_mm, held_east_mm,
                  held_down_mm, loss_level, output ready);
endinterface

interface vfg_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [vfg_pkg::CFG_IDX_W-1:0]    index;
  logic [vfg_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/visual_fix_gate_loss_tracker_core.sv
// Visual fix gate and loss tracker: one result per request, held fix state in flops.
// Depends on vfg_pkg and the channel interfaces in vfg_if.sv.
//
// Rate: one request per clock cycle, sustained while the result sink is ready. A
// request is captured in an input register; one pass of logic (position differences,
// two 23x23 squares, the jump compare and the age compares against the timeouts)
// decides acceptance, updates the held fix and fills the result register. The held
// fix is read and written in the cycle of that pass, so consecutive requests see each
// other's updates without stalls. The result register parts the two channels: a new
// request is taken into a free input register while a result waits. Configuration
// writes are taken every cycle and must come while no request is in flight; the
// squared jump limit is formed at write time.
`default_nettype none

module visual_fix_gate_loss_tracker_core #(
  parameter int POS_BITS  = 24,
  parameter int TIME_BITS = 32
) (
  input  wire       clk,
  input  wire       rst_n,
  vfg_in_if.sink    in_ch,
  vfg_out_if.source out_ch,
  vfg_cfg_if.sink   cfg_ch
);

  localparam int JW     = vfg_pkg::JUMP_W;
  localparam int SQW    = vfg_pkg::SQ_W;
  localparam int TW     = vfg_pkg::TIMEOUT_W;
  localparam int CMP_W  = (POS_BITS > JW) ? POS_BITS : JW;
  localparam int AGE_W  = (TIME_BITS > TW) ? TIME_BITS : TW;

  // Configuration registers
  logic [JW-1:0]  max_jump_r;
  logic [SQW-1:0] max_sq_r;
  logic [TW-1:0]  short_tmo_r;
  logic [TW-1:0]  long_tmo_r;

  // Input register
  logic                        s1_valid_r;
  logic [1:0]                  s1_mode_r;
  logic [TIME_BITS-1:0]        s1_stamp_r;
  logic [POS_BITS-1:0]         s1_north_r;
  logic [POS_BITS-1:0]         s1_east_r;
  logic [POS_BITS-1:0]         s1_down_r;
  logic                        s1_seen_r;

  // Held fix
  logic                 have_fix_r;
  logic [POS_BITS-1:0]  held_north_r;
  logic [POS_BITS-1:0]  held_east_r;
  logic [POS_BITS-1:0]  held_down_r;
  logic [TIME_BITS-1:0] held_stamp_r;

  logic                 have_fix_nxt;
  logic [POS_BITS-1:0]  held_north_nxt;
  logic [POS_BITS-1:0]  held_east_nxt;
  logic [POS_BITS-1:0]  held_down_nxt;
  logic [TIME_BITS-1:0] held_stamp_nxt;

  // Result register
  logic                 out_valid_r;
  logic                 out_accepted_r;
  logic                 out_fresh_r;
  logic [1:0]           out_loss_r;
  logic                 accepted_nxt;
  logic                 fresh_nxt;
  logic [1:0]           loss_nxt;

  logic advance;

  // Datapath terms
  logic [POS_BITS:0]    diff_n;
  logic [POS_BITS:0]    diff_e;
  logic [POS_BITS:0]    absx_n;
  logic [POS_BITS:0]    absx_e;
  logic [CMP_W-1:0]     dist_n;
  logic [CMP_W-1:0]     dist_e;
  logic [CMP_W-1:0]     jump_x;
  logic [JW-1:0]        dn_j;
  logic [JW-1:0]        de_j;
  logic [SQW-1:0]       sq_n;
  logic [SQW-1:0]       sq_e;
  logic [SQW:0]         sq_sum;
  logic                 axis_far;
  logic                 radial_far;
  logic                 stamp_older;
  logic [TIME_BITS-1:0] age;
  logic [AGE_W-1:0]     age_x;
  logic [AGE_W-1:0]     short_x;
  logic [AGE_W-1:0]     long_x;
  logic                 in_window;
  logic                 fix_ok;
  logic                 fresh_old;
  logic [1:0]           loss_old;

  assign advance       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready   = !s1_valid_r || advance;
  assign cfg_ch.ready  = 1'b1;

  // Configuration writes; square the jump limit as it lands
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_jump_r  <= vfg_pkg::MAX_JUMP_RST;
      max_sq_r    <= vfg_pkg::MAX_SQ_RST;
      short_tmo_r <= vfg_pkg::SHORT_TMO_RST;
      long_tmo_r  <= vfg_pkg::LONG_TMO_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        vfg_pkg::CFG_MAX_JUMP: begin
          max_jump_r <= cfg_ch.data[JW-1:0];
          max_sq_r   <= SQW'(cfg_ch.data[JW-1:0]) * SQW'(cfg_ch.data[JW-1:0]);
        end
        vfg_pkg::CFG_SHORT_TMO: short_tmo_r <= cfg_ch.data[TW-1:0];
        vfg_pkg::CFG_LONG_TMO:  long_tmo_r  <= cfg_ch.data[TW-1:0];
        default: ;
      endcase
    end
  end

  // Capture a request when the input register frees up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_mode_r  <= in_ch.mode;
      s1_stamp_r <= in_ch.stamp_ms;
      s1_north_r <= in_ch.north_mm;
      s1_east_r  <= in_ch.east_mm;
      s1_down_r  <= in_ch.down_mm;
      s1_seen_r  <= in_ch.currently_seen;
    end
  end

  // Horizontal jump against the held fix
  always_comb begin
    diff_n = {s1_north_r[POS_BITS-1], s1_north_r} - {held_north_r[POS_BITS-1], held_north_r};
    diff_e = {s1_east_r[POS_BITS-1], s1_east_r} - {held_east_r[POS_BITS-1], held_east_r};
    absx_n = diff_n[POS_BITS] ? (~diff_n + 1'b1) : diff_n;
    absx_e = diff_e[POS_BITS] ? (~diff_e + 1'b1) : diff_e;
    dist_n = CMP_W'(absx_n[POS_BITS-1:0]);
    dist_e = CMP_W'(absx_e[POS_BITS-1:0]);
    jump_x = CMP_W'(max_jump_r);
    axis_far = (dist_n > jump_x) || (dist_e > jump_x);
    // Squares only matter when both axes are within the limit, so their operands fit JW bits
    dn_j   = dist_n[JW-1:0];
    de_j   = dist_e[JW-1:0];
    sq_n   = SQW'(dn_j) * SQW'(dn_j);
    sq_e   = SQW'(de_j) * SQW'(de_j);
    sq_sum = {1'b0, sq_n} + {1'b0, sq_e};
    radial_far = sq_sum > {1'b0, max_sq_r};
  end

  // Age of the held fix at this request's time
  always_comb begin
    stamp_older = s1_stamp_r < held_stamp_r;
    age         = s1_stamp_r - held_stamp_r;
    age_x       = AGE_W'(age);
    short_x     = AGE_W'(short_tmo_r);
    long_x      = AGE_W'(long_tmo_r);
    in_window   = age_x <= long_x;
    fix_ok      = !have_fix_r || (!stamp_older && (!in_window || (!axis_far && !radial_far)));
    fresh_old   = have_fix_r && !stamp_older && (age_x <= short_x);
    if (s1_seen_r) begin
      loss_old = vfg_pkg::LOSS_FRESH;
    end else if (!have_fix_r || stamp_older || (age_x >= long_x)) begin
      loss_old = vfg_pkg::LOSS_LONG;
    end else begin
      loss_old = vfg_pkg::LOSS_SHORT;
    end
  end

  // Update the held fix and form the result
  always_comb begin
    have_fix_nxt   = have_fix_r;
    held_north_nxt = held_north_r;
    held_east_nxt  = held_east_r;
    held_down_nxt  = held_down_r;
    held_stamp_nxt = held_stamp_r;
    accepted_nxt   = 1'b0;
    fresh_nxt      = fresh_old;
    loss_nxt       = loss_old;
    case (s1_mode_r)
      vfg_pkg::MODE_CLEAR: begin
        have_fix_nxt   = 1'b0;
        held_north_nxt = '0;
        held_east_nxt  = '0;
        held_down_nxt  = '0;
        held_stamp_nxt = '0;
        fresh_nxt      = 1'b0;
        loss_nxt       = s1_seen_r ? vfg_pkg::LOSS_FRESH : vfg_pkg::LOSS_LONG;
      end
      vfg_pkg::MODE_FIX: begin
        if (fix_ok) begin
          have_fix_nxt   = 1'b1;
          held_north_nxt = s1_north_r;
          held_east_nxt  = s1_east_r;
          held_down_nxt  = s1_down_r;
          held_stamp_nxt = s1_stamp_r;
          accepted_nxt   = 1'b1;
          // The new fix has age zero
          fresh_nxt      = 1'b1;
          if (s1_seen_r) begin
            loss_nxt = vfg_pkg::LOSS_FRESH;
          end else if (long_tmo_r == '0) begin
            loss_nxt = vfg_pkg::LOSS_LONG;
          end else begin
            loss_nxt = vfg_pkg::LOSS_SHORT;
          end
        end
      end
      default: ;
    endcase
  end

  // Commit held state on each request that moves through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_fix_r   <= 1'b0;
      held_north_r <= '0;
      held_east_r  <= '0;
      held_down_r  <= '0;
      held_stamp_r <= '0;
    end else if (advance) begin
      have_fix_r   <= have_fix_nxt;
      held_north_r <= held_north_nxt;
      held_east_r  <= held_east_nxt;
      held_down_r  <= held_down_nxt;
      held_stamp_r <= held_stamp_nxt;
    end
  end

  // Result register; hold while the sink stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_accepted_r <= accepted_nxt;
      out_fresh_r    <= fresh_nxt;
      out_loss_r     <= loss_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.fix_accepted  = out_accepted_r;
  assign out_ch.fix_fresh     = out_fresh_r;
  assign out_ch.loss_level    = out_loss_r;
  // Held position after the last committed request is what the result reports
  assign out_ch.held_north_mm = held_north_r;
  assign out_ch.held_east_mm  = held_east_r;
  assign out_ch.held_down_mm  = held_down_r;

endmodule

`default_nettype wire

### rtl/core/vfg_checker.sv
// Port-level checks for the visual fix gate and loss tracker, and their bind.
// Depends on visual_fix_gate_loss_tracker_core and the channel interfaces.
`default_nettype none

module vfg_checker #(
  parameter int POS_BITS = 24
) (
  input wire                clk,
  input wire                rst_n,
  input wire                out_valid,
  input wire                out_ready,
  input wire                fix_accepted,
  input wire                fix_fresh,
  input wire [POS_BITS-1:0] held_north_mm,
  input wire [POS_BITS-1:0] held_east_mm,
  input wire [POS_BITS-1:0] held_down_mm,
  input wire [1:0]          loss_level
);

  // No result appears in the cycle after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(fix_accepted) && $stable(fix_fresh) &&
      $stable(held_north_mm) && $stable(held_east_mm) && $stable(held_down_mm) &&
      $stable(loss_level))
    else $error("result payload changed while stalled");

  // A fix just stored has age zero, so it must read fresh
  a_accept_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && fix_accepted |-> fix_fresh)
    else $error("stored fix reported stale");

endmodule

bind visual_fix_gate_loss_tracker_core vfg_checker #(
  .POS_BITS(POS_BITS)
) u_vfg_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .fix_accepted  (out_ch.fix_accepted),
  .fix_fresh     (out_ch.fix_fresh),
  .held_north_mm (out_ch.held_north_mm),
  .held_east_mm  (out_ch.held_east_mm),
  .held_down_mm  (out_ch.held_down_mm),
  .loss_level    (out_ch.loss_level)
);

`default_nettype wire
